// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the priority queue modules; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Types, constants and helpers for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH         = 16;
  localparam int PRIORITY_BITS = 16;
  localparam int SYM_W         = 8;
  localparam int PRIO_PORT_W   = 16;
  localparam int CNT_W         = $clog2(DEPTH + 1);

  typedef logic [SYM_W-1:0]         sym_t;
  typedef logic [PRIORITY_BITS-1:0] prio_t;
  typedef logic [PRIO_PORT_W-1:0]   prio_port_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LIST   = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic insert;
    logic emit;
    logic empty;
    logic last;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cnt_t count;
  } dp_status_t;

  function automatic prio_t to_prio(prio_port_t p);
    logic [63:0] w;
    w = 64'(p);
    return w[PRIORITY_BITS-1:0];
  endfunction

  function automatic prio_port_t to_port(prio_t p);
    logic [63:0] w;
    w = 64'(p);
    return w[PRIO_PORT_W-1:0];
  endfunction

endpackage

// ----- rtl/core/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Sorted store of up to DEPTH symbol/priority entries with insert and list.
// ----------------------------------------------------------------------------
// An insert request leaves busy low, and its single result
// (the request echoed, rejected set when the store is full) strobes in the
// next cycle, so inserts may be issued every cycle. A list request emits one
// result per cycle, starting the cycle after acceptance, for n stored entries
// (one result with empty_res set when empty); busy is high while the cell
// row rotates through the remaining entries. Results are strobed for one
// cycle and must be taken as they come: there is no back-pressure.
module sorted_priority_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                command,
  input  spq_pkg::sym_t       symbol,
  input  spq_pkg::prio_port_t priority_req,
  output logic                strobe,
  output spq_pkg::sym_t       out_symbol,
  output spq_pkg::prio_port_t out_priority,
  output logic                last,
  output logic                empty_res,
  output logic                rejected
);
  import spq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  spq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  spq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .symbol       (symbol),
    .priority_req (priority_req),
    .status       (status),
    .strobe       (strobe),
    .out_symbol   (out_symbol),
    .out_priority (out_priority),
    .last         (last),
    .empty_res    (empty_res),
    .rejected     (rejected)
  );

endmodule

// ----- rtl/core/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Request sequencing: inserts never raise busy; a list of more than one entry holds busy while it drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               command,
  input  spq_pkg::dp_status_t status,
  output spq_pkg::ctrl_cmd_t cmd,
  output logic               busy
);
  import spq_pkg::*;

  state_t state, state_next;
  cnt_t   rem, rem_next;
  logic   accept;

  assign accept = start && !busy;
  assign busy   = (state == ST_LIST);

  always_comb begin
    state_next = state;
    rem_next   = rem;
    unique case (state)
      ST_IDLE: begin
        if (accept && command == CMD_LIST && status.count > cnt_t'(1)) begin
          state_next = ST_LIST;
          rem_next   = status.count - cnt_t'(1);
        end
      end
      ST_LIST: begin
        rem_next = rem - cnt_t'(1);
        if (rem == cnt_t'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.insert = accept && command == CMD_INSERT;
        cmd.emit   = accept && command == CMD_LIST && status.count != '0;
        cmd.empty  = accept && command == CMD_LIST && status.count == '0;
        cmd.last   = status.count == cnt_t'(1);
      end
      ST_LIST: begin
        cmd.emit = 1'b1;
        cmd.last = rem == cnt_t'(1);
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rem   <= '0;
    end else begin
      state <= state_next;
      rem   <= rem_next;
    end
  end

  `ASSERT_ALWAYS(a_list_rem, clk, rst, state != ST_LIST || rem != '0)
  `ASSERT_NEXT(a_list_end, clk, rst, state == ST_LIST && rem == cnt_t'(1), state == ST_IDLE)
  `ASSERT_ALWAYS(a_one_cmd, clk, rst, $onehot0({cmd.insert, cmd.emit, cmd.empty}))

endmodule

// ----- rtl/core/spq_dp.sv -----
// ----------------------------------------------------------------------------
// spq_dp
// Row of compare-and-shift cells holding the sorted entries, plus the
// result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  spq_pkg::ctrl_cmd_t    cmd,
  input  spq_pkg::sym_t         symbol,
  input  spq_pkg::prio_port_t   priority_req,
  output spq_pkg::dp_status_t   status,
  output logic                  strobe,
  output spq_pkg::sym_t         out_symbol,
  output spq_pkg::prio_port_t   out_priority,
  output logic                  last,
  output logic                  empty_res,
  output logic                  rejected
);
  import spq_pkg::*;

  sym_t  cell_sym [DEPTH];
  prio_t cell_pri [DEPTH];
  cnt_t  count;
  prio_t new_pri;
  logic  full;
  logic [DEPTH-1:0] gt;
  logic [DEPTH-1:0] take_prev;

  assign new_pri      = to_prio(priority_req);
  assign full         = count == cnt_t'(DEPTH);
  assign status.count = count;

  // unused cells count as greater, so an entry no smaller than every stored one lands at the tail
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (cnt_t'(i) >= count) || (cell_pri[i] > new_pri);
    end
    take_prev[0] = 1'b0;
    for (int i = 1; i < DEPTH; i++) begin
      take_prev[i] = gt[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && !full) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (gt[i]) begin
          if (take_prev[i]) begin
            cell_sym[i] <= cell_sym[(i + DEPTH - 1) % DEPTH];
            cell_pri[i] <= cell_pri[(i + DEPTH - 1) % DEPTH];
          end else begin
            cell_sym[i] <= symbol;
            cell_pri[i] <= new_pri;
          end
        end
      end
    end else if (cmd.emit) begin
      // rotate the occupied cells by one, front wraps to the tail
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (cnt_t'(i + 1) == count) begin
          cell_sym[i] <= cell_sym[0];
          cell_pri[i] <= cell_pri[0];
        end else begin
          cell_sym[i] <= cell_sym[i+1];
          cell_pri[i] <= cell_pri[i+1];
        end
      end
      cell_sym[DEPTH-1] <= cell_sym[0];
      cell_pri[DEPTH-1] <= cell_pri[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      if (cmd.insert && !full) begin
        count <= count + cnt_t'(1);
      end
      strobe <= cmd.insert || cmd.emit || cmd.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      out_symbol   <= symbol;
      out_priority <= to_port(new_pri);
      last         <= 1'b1;
      empty_res    <= 1'b0;
      rejected     <= full;
    end else if (cmd.emit) begin
      out_symbol   <= cell_sym[0];
      out_priority <= to_port(cell_pri[0]);
      last         <= cmd.last;
      empty_res    <= 1'b0;
      rejected     <= 1'b0;
    end else if (cmd.empty) begin
      out_symbol   <= '0;
      out_priority <= '0;
      last         <= 1'b1;
      empty_res    <= 1'b1;
      rejected     <= 1'b0;
    end
  end

  `ASSERT_ALWAYS(a_count_max, clk, rst, count <= cnt_t'(DEPTH))
  `ASSERT_NEXT(a_ins_count, clk, rst, cmd.insert && !full, count == $past(count) + cnt_t'(1))
  `ASSERT_NEXT(a_emit_count, clk, rst, cmd.emit, $stable(count))
  `ASSERT_ALWAYS(a_flag_last, clk, rst, !strobe || !(empty_res || rejected) || last)

endmodule
